[hdl/tca_pkg.sv]
`default_nettype none

package tca_pkg;

  localparam int SIDE_W = 12;
  localparam int PERIM_W = 14;
  localparam int AREA_W = 25;
  localparam int SIDE_BITS_DEF = 12;

  localparam logic [1:0] SHAPE_NONE = 2'd0;
  localparam logic [1:0] SHAPE_RIGHT = 2'd1;
  localparam logic [1:0] SHAPE_ACUTE = 2'd2;
  localparam logic [1:0] SHAPE_OBTUSE = 2'd3;

  typedef struct packed {
    logic [SIDE_W-1:0] side_a;
    logic [SIDE_W-1:0] side_b;
    logic [SIDE_W-1:0] side_c;
  } tri_in_t;

  typedef struct packed {
    logic is_valid;
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0] area_q2;
    logic [1:0] shape_class;
  } tri_out_t;

endpackage

`default_nettype wire

[hdl/triangle_classify_area_core.sv]
`default_nettype none

// Triangle checker: each transaction carries three side lengths and yields one
// result with the validity flag, the perimeter, four times the Heron area
// (floor of an exact integer square root) and the right/acute/obtuse class.
// The block takes one transaction per cycle while the output is not stalled and
// returns results in order. The sums and the side sorting are registered first,
// then the first products, then the final product and the class, and then the
// square-root pipeline resolves one root bit in each of its stages. Invalid
// inputs still flow through the pipeline and come out with all fields zero. A
// stalled output only holds the stages that are occupied; empty stages keep
// filling.
module triangle_classify_area_core
  import tca_pkg::*;
#(
  parameter int SIDE_BITS = SIDE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire tri_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tri_out_t      out_data
);

  localparam int SUM_W = SIDE_BITS + 2;
  localparam int FAC_W = SIDE_BITS + 1;
  localparam int P1_W = SUM_W + FAC_W;
  localparam int P2_W = 2 * FAC_W;
  localparam int MUL_W = P1_W + P2_W;
  localparam int ROOT_W = 2 * SIDE_BITS + 3;
  localparam int PROD_W = 2 * ROOT_W;
  localparam int SQ_W = 2 * SIDE_BITS;
  localparam int NST = ROOT_W + 3;

  logic [NST-1:0] vld;
  logic [NST:0] adv;

  logic [SIDE_BITS-1:0] a, b, c;
  logic [SUM_W-1:0] sa, sb, sc, sum3;
  logic tri_ok;
  logic [SIDE_BITS-1:0] hi_s, lo1_s, lo2_s;

  logic s1_tri;
  logic [SUM_W-1:0] s1_sum;
  logic [FAC_W-1:0] s1_f1, s1_f2, s1_f3;
  logic [SIDE_BITS-1:0] s1_hi, s1_lo1, s1_lo2;

  logic [P1_W-1:0] p1;
  logic [P2_W-1:0] p2;
  logic [SQ_W-1:0] hsq, l1sq, l2sq;

  logic s2_tri;
  logic [SUM_W-1:0] s2_sum;
  logic [P1_W-1:0] s2_p1;
  logic [P2_W-1:0] s2_p2;
  logic [SQ_W-1:0] s2_hsq, s2_l1sq, s2_l2sq;

  logic [MUL_W-1:0] mul;
  logic [SQ_W:0] sum_sq;
  logic [1:0] cls;

  logic [PROD_W-1:0] rem [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  logic [SUM_W-1:0] sq_sum [ROOT_W+1];
  logic [1:0] sq_cls [ROOT_W+1];
  logic sq_tri [ROOT_W+1];

  always_comb begin
    logic go;
    go = out_ready;
    adv[NST] = go;
    for (int i = NST - 1; i >= 0; i--) begin
      go = ~vld[i] | go;
      adv[i] = go;
    end
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign a = SIDE_BITS'(in_data.side_a);
  assign b = SIDE_BITS'(in_data.side_b);
  assign c = SIDE_BITS'(in_data.side_c);
  assign sa = SUM_W'(a);
  assign sb = SUM_W'(b);
  assign sc = SUM_W'(c);
  assign sum3 = sa + sb + sc;
  assign tri_ok = (sa + sb > sc) && (sa + sc > sb) && (sb + sc > sa);

  always_comb begin
    if (a >= b && a >= c) begin
      hi_s = a;
      lo1_s = b;
      lo2_s = c;
    end else if (b >= c) begin
      hi_s = b;
      lo1_s = a;
      lo2_s = c;
    end else begin
      hi_s = c;
      lo1_s = a;
      lo2_s = b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_tri <= tri_ok;
      s1_sum <= sum3;
      s1_f1 <= FAC_W'(sb + sc - sa);
      s1_f2 <= FAC_W'(sa + sc - sb);
      s1_f3 <= FAC_W'(sa + sb - sc);
      s1_hi <= hi_s;
      s1_lo1 <= lo1_s;
      s1_lo2 <= lo2_s;
    end
  end

  assign p1 = s1_sum * s1_f1;
  assign p2 = s1_f2 * s1_f3;
  assign hsq = s1_hi * s1_hi;
  assign l1sq = s1_lo1 * s1_lo1;
  assign l2sq = s1_lo2 * s1_lo2;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_tri <= s1_tri;
      s2_sum <= s1_sum;
      s2_p1 <= p1;
      s2_p2 <= p2;
      s2_hsq <= hsq;
      s2_l1sq <= l1sq;
      s2_l2sq <= l2sq;
    end
  end

  assign mul = s2_p1 * s2_p2;
  assign sum_sq = (SQ_W+1)'(s2_l1sq) + (SQ_W+1)'(s2_l2sq);

  always_comb begin
    if (sum_sq == (SQ_W+1)'(s2_hsq)) begin
      cls = SHAPE_RIGHT;
    end else if (sum_sq > (SQ_W+1)'(s2_hsq)) begin
      cls = SHAPE_ACUTE;
    end else begin
      cls = SHAPE_OBTUSE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      rem[0] <= PROD_W'(mul);
      root[0] <= '0;
      sq_sum[0] <= s2_sum;
      sq_cls[0] <= cls;
      sq_tri[0] <= s2_tri;
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [PROD_W-1:0] trial;
    logic take;

    assign trial = (PROD_W'(root[j]) << (K + 1)) | (PROD_W'(1) << (2 * K));
    assign take = rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (adv[j+3]) begin
        rem[j+1] <= take ? rem[j] - trial : rem[j];
        root[j+1] <= take ? (root[j] | (ROOT_W'(1) << K)) : root[j];
        sq_sum[j+1] <= sq_sum[j];
        sq_cls[j+1] <= sq_cls[j];
        sq_tri[j+1] <= sq_tri[j];
      end
    end
  end

  assign out_valid = vld[NST-1];

  always_comb begin
    out_data.is_valid = sq_tri[ROOT_W];
    out_data.perimeter = sq_tri[ROOT_W] ? PERIM_W'(sq_sum[ROOT_W]) : '0;
    out_data.area_q2 = sq_tri[ROOT_W] ? AREA_W'(root[ROOT_W]) : '0;
    out_data.shape_class = sq_tri[ROOT_W] ? sq_cls[ROOT_W] : SHAPE_NONE;
  end

  // Final square-root remainder never exceeds twice the root.
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, rem[ROOT_W]} <= ({1'b0, PROD_W'(root[ROOT_W])} << 1)))
    else $error("square root remainder out of range");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-2] && !adv[NST-2]) |=> vld[NST-2])
    else $error("stalled transaction dropped from the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  import tca_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * SIDE_BITS_DEF + 6 + 10;
  localparam int STALL_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tri_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tri_out_t out_data;

  tri_out_t triangle_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;
  event hold_start;

  triangle_classify_area_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Exact Heron area and side-square comparison on 64-bit integers.
  function automatic tri_out_t heron_classify(tri_in_t t);
    longint unsigned a, b, c, hi, perim, prod, root, cand, short_sq, long_sq;
    tri_out_t r;
    r = '0;
    a = 64'(t.side_a);
    b = 64'(t.side_b);
    c = 64'(t.side_c);
    if (a + b > c && a + c > b && b + c > a) begin
      perim = a + b + c;
      prod = perim * (b + c - a) * (a + c - b) * (a + b - c);
      root = 0;
      for (int i = 31; i >= 0; i--) begin
        cand = root | (64'd1 << i);
        if (cand * cand <= prod) begin
          root = cand;
        end
      end
      hi = a;
      if (b > hi) begin
        hi = b;
      end
      if (c > hi) begin
        hi = c;
      end
      long_sq = hi * hi;
      short_sq = a * a + b * b + c * c - long_sq;
      r.is_valid = 1'b1;
      r.perimeter = perim[PERIM_W-1:0];
      r.area_q2 = root[AREA_W-1:0];
      if (short_sq == long_sq) begin
        r.shape_class = SHAPE_RIGHT;
      end else if (short_sq > long_sq) begin
        r.shape_class = SHAPE_ACUTE;
      end else begin
        r.shape_class = SHAPE_OBTUSE;
      end
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic send_triangle(input int a, input int b, input int c);
    tri_in_t item;
    item.side_a = SIDE_W'(a);
    item.side_b = SIDE_W'(b);
    item.side_c = SIDE_W'(c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    triangle_results.push_back(heron_classify(item));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("triangle_classify_area_core regression: fail");
      $finish;
    end
  end

  always begin
    @(hold_start);
    hold_left <= STALL_CYCLES;
    repeat (STALL_CYCLES) begin
      @(posedge clk);
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    tri_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (triangle_results.size() == 0) begin
          report_error($sformatf("unexpected transaction %h", out_data));
        end else begin
          want = triangle_results.pop_front();
          if (out_data.is_valid !== want.is_valid) begin
            report_error($sformatf("is_valid %b, expected %b", out_data.is_valid,
                                   want.is_valid));
          end
          if (out_data.perimeter !== want.perimeter) begin
            report_error($sformatf("perimeter %0d, expected %0d", out_data.perimeter,
                                   want.perimeter));
          end
          if (out_data.area_q2 !== want.area_q2) begin
            report_error($sformatf("area_q2 %0d, expected %0d", out_data.area_q2,
                                   want.area_q2));
          end
          if (out_data.shape_class !== want.shape_class) begin
            report_error($sformatf("shape_class %0d, expected %0d", out_data.shape_class,
                                   want.shape_class));
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_triangle(0, 0, 0);
    send_triangle(0, 5, 5);
    send_triangle(4095, 0, 4095);
    send_triangle(1, 1, 1);
    send_triangle(4095, 4095, 4095);
    send_triangle(4095, 4095, 4094);
    send_triangle(4095, 4095, 1);
    send_triangle(1, 4095, 1);
    send_triangle(3, 4, 5);
    send_triangle(5, 3, 4);
    send_triangle(4, 5, 3);
    send_triangle(2304, 3072, 3840);
    send_triangle(1, 2, 3);
    send_triangle(1, 1, 2);
    send_triangle(2048, 2047, 4095);
    send_triangle(2047, 2048, 4094);
    send_triangle(2, 2, 3);
    send_triangle(4, 4, 5);
    send_triangle(5, 5, 3);
    send_triangle(5, 3, 5);
    send_triangle(3, 5, 5);
    send_triangle(5, 5, 8);
    send_triangle(2730, 1365, 2730);
    send_triangle(4094, 2, 4095);
  endtask

  // Mostly well-formed triangles of every shape, with degenerate and raw noise mixed in.
  task automatic test_random_mix(input int send_pct, input int recv_pct, input int count);
    int x, y, z, lo, hi, m, n, k, span;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      span = ($urandom_range(3) == 0) ? 63 : 4095;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          x = $urandom_range(1, span);
          y = $urandom_range(1, span);
          lo = (x > y) ? x - y + 1 : y - x + 1;
          hi = (x + y - 1 > 4095) ? 4095 : x + y - 1;
          z = $urandom_range(lo, hi);
        end
        5: begin
          m = $urandom_range(2, 45);
          n = $urandom_range(1, m - 1);
          k = $urandom_range(1, 4095 / (m * m + n * n));
          x = k * (m * m - n * n);
          y = k * 2 * m * n;
          z = k * (m * m + n * n);
        end
        6: begin
          x = $urandom_range(1, span);
          y = x;
          z = ($urandom_range(1) == 0) ? x : $urandom_range(1, (2 * x - 1 > 4095) ? 4095 : 2 * x - 1);
        end
        7: begin
          x = $urandom_range(0, 2047);
          y = $urandom_range(0, 2048);
          z = x + y;
        end
        default: begin
          x = $urandom_range(0, 4095);
          y = $urandom_range(0, 4095);
          z = ($urandom_range(7) == 0) ? 0 : $urandom_range(0, 4095);
        end
      endcase
      case ($urandom_range(5))
        0: send_triangle(x, y, z);
        1: send_triangle(x, z, y);
        2: send_triangle(y, x, z);
        3: send_triangle(y, z, x);
        4: send_triangle(z, x, y);
        default: send_triangle(z, y, x);
      endcase
    end
  endtask

  // The receiver stops for a long stretch so the pipeline fills and pushes back.
  task automatic test_long_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_start;
    for (int i = 0; i < 150; i++) begin
      send_triangle($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_mix(12, 78, 310);
    test_random_mix(78, 12, 310);
    test_random_mix(0, 0, 310);
    test_long_stall();
    in_valid <= 1'b0;
    while (triangle_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("triangle_classify_area_core regression: pass");
    end else begin
      $display("triangle_classify_area_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
